// ===== rtl/core/xlsf_pkg.sv =====
// ----------------------------------------------------------------------------
// xlsf_pkg
// Shared types and constants for the logic, shift and flag unit.
// ----------------------------------------------------------------------------
package xlsf_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int COUNT_W    = 5;
	localparam int CMD_W      = 4;
	localparam int SIZE_W     = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_TEST = 4'd0,
		CMD_AND  = 4'd1,
		CMD_XOR  = 4'd2,
		CMD_OR   = 4'd3,
		CMD_ROL  = 4'd4,
		CMD_ROR  = 4'd5,
		CMD_SAR  = 4'd6,
		CMD_SHL  = 4'd7,
		CMD_SHR  = 4'd8,
		CMD_BSR  = 4'd9,
		CMD_NOT  = 4'd10
	} cmd_t;

	localparam logic [SIZE_W-1:0] SIZE_BYTE  = 2'd0;
	localparam logic [SIZE_W-1:0] SIZE_WORD  = 2'd1;

	typedef struct packed {
		logic [CMD_W-1:0]      command;
		logic [SIZE_W-1:0]     operand_size;
		logic [DATA_WIDTH-1:0] dest_value;
		logic [DATA_WIDTH-1:0] src_value;
	} xlsf_op_t;

	typedef struct packed {
		logic                  cf_of_clear;
		logic                  sf_value;
		logic                  sf_write;
		logic                  zf_value;
		logic                  zf_write;
		logic                  write_result;
		logic [DATA_WIDTH-1:0] result;
	} xlsf_res_t;

endpackage

// ===== rtl/core/xlsf_alu.sv =====
// ----------------------------------------------------------------------------
// xlsf_alu
// Combinational logic, shift, rotate, bit-scan and complement datapath with flag outputs.
// ----------------------------------------------------------------------------
module xlsf_alu
	import xlsf_pkg::*;
(
	input  xlsf_op_t  op,
	output xlsf_res_t res
);

	always_comb begin
		logic [DATA_WIDTH-1:0]   mask;
		logic [DATA_WIDTH-1:0]   d;
		logic [DATA_WIDTH-1:0]   s;
		logic [COUNT_W-1:0]      cnt;
		logic [COUNT_W-1:0]      rot_n;
		logic [DATA_WIDTH-1:0]   rep;
		logic [2*DATA_WIDTH-1:0] rol_w;
		logic [2*DATA_WIDTH-1:0] ror_w;
		logic                    sign;
		logic [DATA_WIDTH-1:0]   ext;
		logic [COUNT_W-1:0]      bsr_idx;
		logic [DATA_WIDTH-1:0]   r;
		logic                    wr;
		logic                    zfsf;
		logic                    clr;
		logic                    bsr_op;
		logic                    top;

		case (op.operand_size)
			SIZE_BYTE: begin
				mask  = 32'h0000_00ff;
				rep   = {4{op.dest_value[7:0]}};
				rot_n = {2'b00, op.src_value[2:0]};
				sign  = op.dest_value[7];
			end
			SIZE_WORD: begin
				mask  = 32'h0000_ffff;
				rep   = {2{op.dest_value[15:0]}};
				rot_n = {1'b0, op.src_value[3:0]};
				sign  = op.dest_value[15];
			end
			default: begin
				mask  = 32'hffff_ffff;
				rep   = op.dest_value;
				rot_n = op.src_value[COUNT_W-1:0];
				sign  = op.dest_value[DATA_WIDTH-1];
			end
		endcase

		d     = op.dest_value & mask;
		s     = op.src_value & mask;
		cnt   = op.src_value[COUNT_W-1:0];
		rol_w = {rep, rep} << cnt;
		ror_w = {rep, rep} >> cnt;
		ext   = d | (sign ? ~mask : '0);

		bsr_idx = '0;
		for (int i = 0; i < DATA_WIDTH; i++) begin
			if (s[i])
				bsr_idx = COUNT_W'(i);
		end

		r      = '0;
		wr     = 1'b0;
		zfsf   = 1'b0;
		clr    = 1'b0;
		bsr_op = 1'b0;
		case (cmd_t'(op.command))
			CMD_TEST: begin
				r    = d & s;
				zfsf = 1'b1;
				clr  = 1'b1;
			end
			CMD_AND: begin
				r    = d & s;
				wr   = 1'b1;
				zfsf = 1'b1;
				clr  = 1'b1;
			end
			CMD_XOR: begin
				r    = d ^ s;
				wr   = 1'b1;
				zfsf = 1'b1;
				clr  = 1'b1;
			end
			CMD_OR: begin
				r    = d | s;
				wr   = 1'b1;
				zfsf = 1'b1;
				clr  = 1'b1;
			end
			CMD_ROL: begin
				r  = rol_w[2*DATA_WIDTH-1:DATA_WIDTH];
				wr = (rot_n != '0);
			end
			CMD_ROR: begin
				r  = ror_w[DATA_WIDTH-1:0];
				wr = (rot_n != '0);
			end
			CMD_SAR: begin
				r    = DATA_WIDTH'($signed(ext) >>> cnt);
				wr   = 1'b1;
				zfsf = 1'b1;
			end
			CMD_SHL: begin
				r    = d << cnt;
				wr   = 1'b1;
				zfsf = 1'b1;
			end
			CMD_SHR: begin
				r    = d >> cnt;
				wr   = 1'b1;
				zfsf = 1'b1;
			end
			CMD_BSR: begin
				r      = {{(DATA_WIDTH-COUNT_W){1'b0}}, bsr_idx};
				wr     = (s != '0);
				bsr_op = 1'b1;
			end
			CMD_NOT: begin
				r  = ~d;
				wr = 1'b1;
			end
			default: begin
				r = '0;
			end
		endcase

		r = r & mask;

		case (op.operand_size)
			SIZE_BYTE: top = r[7];
			SIZE_WORD: top = r[15];
			default:   top = r[DATA_WIDTH-1];
		endcase

		res.result       = wr ? r : '0;
		res.write_result = wr;
		res.zf_write     = zfsf | bsr_op;
		res.zf_value     = zfsf ? (r == '0) : (bsr_op & (s == '0));
		res.sf_write     = zfsf;
		res.sf_value     = zfsf & top;
		res.cf_of_clear  = clr;
	end

endmodule

// ===== rtl/core/x86_logic_shift_flag_unit.sv =====
// ----------------------------------------------------------------------------
// x86_logic_shift_flag_unit
// Logic, shift, rotate, bit-scan and complement unit with flag update outputs.
//
// Input stream (s_*): one operation per word. tuser carries the command and
// the operand size, tdata carries the destination and source operands.
// Output stream (m_*): one result word per operation, in order. tdata holds
// the width-truncated result, tuser the write-back and flag controls.
// The input register captures each accepted operation, and the result
// register captures its ALU result and presents it on the output stream.
// One operation per cycle is taken while the receiver keeps up: the two
// pipeline registers advance together whenever the result register is empty
// or being taken. When the receiver stalls, the result register holds, the
// input register fills and s_tready drops only once both stages are occupied.
// Reset clears both stage valid bits; no output word is presented until a new
// input word has been accepted.
// ----------------------------------------------------------------------------
module x86_logic_shift_flag_unit
	import xlsf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [63:0]           s_tdata,  // dest_value[31:0], src_value[63:32]
	input  logic [5:0]            s_tuser,  // command[3:0], operand_size[5:4]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,  // result[31:0]
	output logic [5:0]            m_tuser   // write_result, zf_write, zf_value,
	                                        // sf_write, sf_value, cf_of_clear
);

	xlsf_op_t  op_s1;
	logic      valid_s1;
	xlsf_res_t res_s2;
	logic      valid_s2;
	xlsf_res_t alu_res;
	logic      adv_s2;
	logic      adv_s1;

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= s_tvalid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			op_s1.command      <= s_tuser[3:0];
			op_s1.operand_size <= s_tuser[5:4];
			op_s1.dest_value   <= s_tdata[31:0];
			op_s1.src_value    <= s_tdata[63:32];
		end
		if (adv_s2 && valid_s1)
			res_s2 <= alu_res;
	end

	xlsf_alu u_alu (
		.op  (op_s1),
		.res (alu_res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2.result;
	assign m_tuser  = {res_s2.cf_of_clear, res_s2.sf_value, res_s2.sf_write,
	                   res_s2.zf_value, res_s2.zf_write, res_s2.write_result};

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream-level bench for x86_logic_shift_flag_unit: drives operation words,
// predicts each result word with an independent model of the logic, shift,
// rotate, bit-scan and complement rules, and checks results in order.
// ----------------------------------------------------------------------------
module tb
	import xlsf_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	class alu_scoreboard;
		xlsf_res_t pending_results[$];
		int mismatches;

		function new();
			mismatches = 0;
		endfunction

		function xlsf_res_t predict_outcome(xlsf_op_t op);
			int unsigned wb;
			int unsigned n;
			logic [31:0] mask, d, s, r;
			logic [4:0] cnt;
			logic zfsf;
			xlsf_res_t e;
			wb = (op.operand_size == SIZE_BYTE) ? 8 : (op.operand_size == SIZE_WORD) ? 16 : 32;
			mask = (wb == 32) ? 32'hffffffff : ((32'd1 << wb) - 32'd1);
			d = op.dest_value & mask;
			s = op.src_value & mask;
			cnt = op.src_value[4:0];
			r = '0;
			e = '0;
			zfsf = 1'b0;
			case (op.command)
				CMD_TEST: begin
					r = d & s;
					zfsf = 1'b1;
					e.cf_of_clear = 1'b1;
				end
				CMD_AND: begin
					r = d & s;
					e.write_result = 1'b1;
					zfsf = 1'b1;
					e.cf_of_clear = 1'b1;
				end
				CMD_XOR: begin
					r = d ^ s;
					e.write_result = 1'b1;
					zfsf = 1'b1;
					e.cf_of_clear = 1'b1;
				end
				CMD_OR: begin
					r = d | s;
					e.write_result = 1'b1;
					zfsf = 1'b1;
					e.cf_of_clear = 1'b1;
				end
				CMD_ROL, CMD_ROR: begin
					n = cnt % wb;
					if (n != 0) begin
						if (op.command == CMD_ROL)
							r = (d << n) | (d >> (wb - n));
						else
							r = (d >> n) | (d << (wb - n));
						e.write_result = 1'b1;
					end
				end
				CMD_SAR: begin
					if (d[wb-1])
						r = ~((~(d | ~mask)) >> cnt);
					else
						r = d >> cnt;
					e.write_result = 1'b1;
					zfsf = 1'b1;
				end
				CMD_SHL: begin
					r = d << cnt;
					e.write_result = 1'b1;
					zfsf = 1'b1;
				end
				CMD_SHR: begin
					r = d >> cnt;
					e.write_result = 1'b1;
					zfsf = 1'b1;
				end
				CMD_BSR: begin
					e.zf_write = 1'b1;
					if (s == '0) begin
						e.zf_value = 1'b1;
					end else begin
						for (int i = 0; i < wb; i++)
							if (s[i])
								r = i;
						e.write_result = 1'b1;
					end
				end
				CMD_NOT: begin
					r = ~d;
					e.write_result = 1'b1;
				end
				default: ;
			endcase
			r &= mask;
			if (zfsf) begin
				e.zf_write = 1'b1;
				e.zf_value = (r == '0);
				e.sf_write = 1'b1;
				e.sf_value = r[wb-1];
			end
			e.result = (e.write_result && op.command != CMD_TEST) ? r : '0;
			return e;
		endfunction

		function void note_op(xlsf_op_t op);
			pending_results.push_back(predict_outcome(op));
		endfunction

		function void check_word(xlsf_res_t got);
			xlsf_res_t want;
			logic [31:0] ev[7];
			logic [31:0] av[7];
			string nm[7];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			nm = '{"result", "write_result", "zf_write", "zf_value", "sf_write", "sf_value",
				"cf_of_clear"};
			ev = '{want.result, want.write_result, want.zf_write, want.zf_value,
				want.sf_write, want.sf_value, want.cf_of_clear};
			av = '{got.result, got.write_result, got.zf_write, got.zf_value,
				got.sf_write, got.sf_value, got.cf_of_clear};
			for (int i = 0; i < 7; i++)
				if (ev[i] !== av[i]) begin
					$display("%0t: %s expected %h actual %h", $time, nm[i], ev[i], av[i]);
					mismatches++;
				end
		endfunction
	endclass

	localparam logic [SIZE_W-1:0] SIZE_DWORD = 2'd2;
	localparam logic [SIZE_W-1:0] SIZE_WIDE  = 2'd3;
	localparam logic [CMD_W-1:0]  CMD_UNK_LO = 4'(CMD_NOT) + 4'd1;
	localparam logic [CMD_W-1:0]  CMD_UNK_HI = 4'hf;
	localparam int PHASE_ITEMS = 350;
	localparam int HOLD_OFF    = 300;
	localparam int WATCHDOG    = 2000;
	localparam int DRAIN       = 8;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [5:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [5:0]  m_tuser;

	alu_scoreboard sb;
	int send_idle = 0;
	int recv_stall = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	x86_logic_shift_flag_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	always @(posedge clk) begin
		xlsf_op_t op;
		if (s_tvalid && s_tready) begin
			op.command = s_tuser[3:0];
			op.operand_size = s_tuser[5:4];
			op.dest_value = s_tdata[31:0];
			op.src_value = s_tdata[63:32];
			sb.note_op(op);
		end
		if (m_tvalid && m_tready)
			sb.check_word(xlsf_res_t'({m_tuser, m_tdata}));
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG) begin
			$display("%0t: no progress for %0d cycles", $time, WATCHDOG);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_op(input xlsf_op_t op);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {op.src_value, op.dest_value};
		s_tuser <= {op.operand_size, op.command};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	function automatic xlsf_op_t make_op(logic [3:0] cmd, logic [1:0] sz, logic [31:0] d,
		logic [31:0] s);
		xlsf_op_t op;
		op.command = cmd;
		op.operand_size = sz;
		op.dest_value = d;
		op.src_value = s;
		return op;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return 32'd1 << $urandom_range(31);
			3: return ~(32'd1 << $urandom_range(31));
			4: return 32'($urandom_range(255));
			default: return $urandom;
		endcase
	endfunction

	function automatic xlsf_op_t random_op();
		logic [3:0] cmd;
		logic [1:0] sz;
		if ($urandom_range(99) < 3)
			cmd = 4'($urandom_range(CMD_UNK_HI, CMD_UNK_LO));
		else
			cmd = 4'($urandom_range(CMD_NOT, CMD_TEST));
		if ($urandom_range(99) < 3)
			sz = SIZE_WIDE;
		else
			sz = 2'($urandom_range(SIZE_DWORD, SIZE_BYTE));
		return make_op(cmd, sz, rand_word(), rand_word());
	endfunction

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(make_op(CMD_TEST, SIZE_BYTE, 32'hffffffff, 32'h000000ff));
		send_op(make_op(CMD_AND, SIZE_WORD, 32'h0000ffff, 32'hffff0000));
		send_op(make_op(CMD_XOR, SIZE_DWORD, 32'hffffffff, 32'hffffffff));
		send_op(make_op(CMD_OR, SIZE_DWORD, 32'h80000000, 32'h00000000));
		send_op(make_op(CMD_ROL, SIZE_BYTE, 32'h00000081, 32'd9));
		send_op(make_op(CMD_ROL, SIZE_WORD, 32'h00001234, 32'd16));
		send_op(make_op(CMD_ROR, SIZE_DWORD, 32'h80000001, 32'hffffffff));
		send_op(make_op(CMD_ROR, SIZE_BYTE, 32'h000000a5, 32'd0));
		send_op(make_op(CMD_SAR, SIZE_BYTE, 32'h00000080, 32'd31));
		send_op(make_op(CMD_SAR, SIZE_DWORD, 32'h80000000, 32'd1));
		send_op(make_op(CMD_SAR, SIZE_WORD, 32'hffff7fff, 32'd15));
		send_op(make_op(CMD_SHL, SIZE_DWORD, 32'hffffffff, 32'd31));
		send_op(make_op(CMD_SHL, SIZE_BYTE, 32'h000000ff, 32'd8));
		send_op(make_op(CMD_SHR, SIZE_WORD, 32'h00008000, 32'd15));
		send_op(make_op(CMD_SHR, SIZE_BYTE, 32'hffffffff, 32'hffffffe0));
		send_op(make_op(CMD_BSR, SIZE_DWORD, 32'h12345678, 32'h00000000));
		send_op(make_op(CMD_BSR, SIZE_DWORD, 32'h00000000, 32'hffffffff));
		send_op(make_op(CMD_BSR, SIZE_BYTE, 32'h00000000, 32'h00000100));
		send_op(make_op(CMD_NOT, SIZE_BYTE, 32'hffffff00, 32'h00000000));
		send_op(make_op(CMD_NOT, SIZE_DWORD, 32'hffffffff, 32'hffffffff));
		send_op(make_op(CMD_AND, SIZE_WIDE, 32'hf0f0f0f0, 32'hff00ff00));
		send_op(make_op(CMD_ROL, SIZE_WIDE, 32'h80000000, 32'd33));
		send_op(make_op(CMD_UNK_LO, SIZE_DWORD, 32'hffffffff, 32'hffffffff));
		send_op(make_op(CMD_UNK_HI, SIZE_WIDE, 32'hffffffff, 32'hffffffff));

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 73; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 73; end
				3: begin send_idle = 6;  recv_stall = 6;  end
				default: begin
					send_idle = 0;
					recv_stall = 0;
					hold_cycles = HOLD_OFF;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_op(random_op());
		end
		s_tvalid <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/xlsf_pkg.sv
rtl/core/xlsf_alu.sv
rtl/core/x86_logic_shift_flag_unit.sv
bench/tb.sv
